[rtl/core/rbc_pkg.sv]
// ----------------------------------------------------------------------------
// rbc_pkg
// Shared widths, constants and link types of the radix base converter.
// ----------------------------------------------------------------------------
package rbc_pkg;

    localparam int VAL_W     = 63;
    localparam int DIG_W     = 4;
    localparam int BASE_W    = 5;
    localparam int SB_W      = 4;
    localparam int DEC_CELLS = 19;

    localparam logic [BASE_W-1:0] DEC_BASE = BASE_W'(10);
    localparam logic [BASE_W-1:0] TB_MIN   = BASE_W'(2);
    localparam logic [BASE_W-1:0] TB_MAX   = BASE_W'(16);

    typedef enum logic {
        CFG_SOURCE_BASE = 1'b0,
        CFG_TARGET_BASE = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic en;
        logic carry;
    } t_link;

    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

endpackage

[rtl/core/rbc_cell.sv]
// ----------------------------------------------------------------------------
// rbc_cell
// One digit cell: doubles its digit plus the incoming carry modulo the base
// and hands the carry up, or shifts digits up for readout.
// ----------------------------------------------------------------------------
module rbc_cell
    import rbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [BASE_W-1:0] i_base,
    input  t_link             i_link,
    input  logic [DIG_W-1:0]  i_shift_in,
    output t_link             o_link,
    output logic [DIG_W-1:0]  o_digit
);

    logic [DIG_W-1:0]  r_digit;
    t_link             r_link;
    logic [DIG_W:0]    w_sum;
    logic              w_wrap;

    assign w_sum  = {r_digit, i_link.carry};
    assign w_wrap = w_sum >= i_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else if (i_ctl.clear || i_ctl.shift) begin
            r_link <= '0;
        end else if (i_link.en) begin
            r_link <= '{en: 1'b1, carry: w_wrap};
        end else begin
            r_link <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_digit <= '0;
        end else if (i_ctl.shift) begin
            r_digit <= i_shift_in;
        end else if (i_link.en) begin
            r_digit <= w_wrap ? DIG_W'(w_sum - i_base) : w_sum[DIG_W-1:0];
        end
    end

    assign o_link  = r_link;
    assign o_digit = r_digit;

endmodule

[rtl/core/rbc_chain.sv]
// ----------------------------------------------------------------------------
// rbc_chain
// Row of digit cells, least significant at the bottom; bits enter at the
// bottom most significant first and the top digit is read out.
// ----------------------------------------------------------------------------
module rbc_chain
    import rbc_pkg::*;
#(
    parameter int CELLS = 19
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [BASE_W-1:0] i_base,
    input  t_link             i_feed,
    output logic [DIG_W-1:0]  o_top,
    output t_link             o_spill
);

    t_link            w_link [0:CELLS];
    logic [DIG_W-1:0] w_dig  [0:CELLS];

    assign w_link[0] = i_feed;
    assign w_dig[0]  = '0;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        rbc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_base     (i_base),
            .i_link     (w_link[g]),
            .i_shift_in (w_dig[g]),
            .o_link     (w_link[g+1]),
            .o_digit    (w_dig[g+1])
        );
    end

    assign o_top   = w_dig[CELLS];
    assign o_spill = w_link[CELLS];

endmodule

[rtl/core/radix_base_converter.sv]
// ----------------------------------------------------------------------------
// radix_base_converter
// Reads the decimal digits of each word in the source base and emits the
// value as target-base digits, most significant first.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  s        in   i_s_tvalid/o_s_tready i_s_tdata[62:0] coded_value
//  m        out  o_m_tvalid/i_m_tready o_m_tdata[3:0] out_digit, tlast, tuser
//  cfg      in   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
//  One word at a time: decimal split in a 19-cell row, weighting in the
//  source base, target split in a MAX_DIGITS-cell row, then readout, which
//  holds while m stalls. A rejected word skips the target split and readout.
//  The result register lets the next word enter while the last digit waits.
//  Reset is synchronous and clears control state, config and the accumulator, not the digits.
// ----------------------------------------------------------------------------
module radix_base_converter
    import rbc_pkg::*;
#(
    parameter int MAX_DIGITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,     // [62:0] coded_value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,     // [3:0] out_digit
    output logic        o_m_tlast,     // final_digit
    output logic        o_m_tuser,     // [0] bad_digit
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    localparam int CW = $clog2(VAL_W + MAX_DIGITS);
    localparam logic [CW-1:0] DEC_LAST  = CW'(VAL_W + DEC_CELLS - 2);
    localparam logic [CW-1:0] HORN_LAST = CW'(DEC_CELLS - 1);
    localparam logic [CW-1:0] TGT_LAST  = CW'(VAL_W + MAX_DIGITS - 2);
    localparam logic [CW-1:0] FEED_LEN  = CW'(VAL_W);
    localparam logic [CW-1:0] EMIT_LEN  = CW'(MAX_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_HORN,
        S_TGT,
        S_EMIT,
        S_ERR
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_cnt;
    logic [VAL_W-1:0]  r_acc;
    logic              r_bad;
    logic              r_started;
    logic [SB_W-1:0]   r_sb;
    logic [BASE_W-1:0] r_tb;
    logic              r_ovalid;
    logic [DIG_W-1:0]  r_odig;
    logic              r_olast;
    logic              r_obad;

    logic [BASE_W-1:0] w_tb;
    logic              w_accept;
    logic              w_feed;
    t_link             w_dec_feed;
    t_link             w_tgt_feed;
    t_cell_ctl         w_dec_ctl;
    t_cell_ctl         w_tgt_ctl;
    logic [DIG_W-1:0]  w_dec_top;
    logic [DIG_W-1:0]  w_tgt_top;
    t_link             w_dec_spill;
    t_link             w_tgt_spill;
    logic [VAL_W-1:0]  w_horner;
    logic              w_dig_bad;
    logic              w_out_free;
    logic              w_skip;
    logic              w_emit;

    assign w_tb = (r_tb < TB_MIN) ? TB_MIN : ((r_tb > TB_MAX) ? TB_MAX : r_tb);

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;

    assign w_feed     = ((r_state == S_DEC) || (r_state == S_TGT)) && (r_cnt < FEED_LEN);
    assign w_dec_feed = '{en: w_feed && (r_state == S_DEC), carry: r_acc[VAL_W-1]};
    assign w_tgt_feed = '{en: w_feed && (r_state == S_TGT), carry: r_acc[VAL_W-1]};

    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_skip     = (r_state == S_EMIT) && !r_started && (w_tgt_top == '0)
                        && (r_cnt > CW'(1));
    assign w_emit     = (r_state == S_EMIT) && !w_skip && w_out_free;

    assign w_dec_ctl = '{clear: w_accept, shift: (r_state == S_HORN)};
    assign w_tgt_ctl = '{clear: w_accept, shift: w_skip || w_emit};

    assign w_horner  = r_acc * VAL_W'(r_sb) + VAL_W'(w_dec_top);
    assign w_dig_bad = w_dec_top >= r_sb;

    rbc_chain #(
        .CELLS (DEC_CELLS)
    ) u_dec_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_dec_ctl),
        .i_base  (DEC_BASE),
        .i_feed  (w_dec_feed),
        .o_top   (w_dec_top),
        .o_spill (w_dec_spill)
    );

    rbc_chain #(
        .CELLS (MAX_DIGITS)
    ) u_tgt_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tgt_ctl),
        .i_base  (w_tb),
        .i_feed  (w_tgt_feed),
        .o_top   (w_tgt_top),
        .o_spill (w_tgt_spill)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_bad     <= 1'b0;
            r_started <= 1'b0;
            r_sb      <= SB_W'(10);
            r_tb      <= BASE_W'(2);
            r_ovalid  <= 1'b0;
            r_acc     <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_SOURCE_BASE: r_sb <= i_cfg_data[SB_W-1:0];
                    CFG_TARGET_BASE: r_tb <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_emit || ((r_state == S_ERR) && w_out_free)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            if (w_feed) begin
                r_acc <= {r_acc[VAL_W-2:0], 1'b0};
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_acc   <= i_s_tdata[VAL_W-1:0];
                        r_cnt   <= '0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_cnt == DEC_LAST) begin
                        r_cnt   <= '0;
                        r_bad   <= 1'b0;
                        r_state <= S_HORN;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_HORN: begin
                    r_acc <= w_horner;
                    r_bad <= r_bad || w_dig_bad;
                    if (r_cnt == HORN_LAST) begin
                        r_cnt   <= '0;
                        r_state <= (r_bad || w_dig_bad) ? S_ERR : S_TGT;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_TGT: begin
                    if (r_cnt == TGT_LAST) begin
                        r_cnt     <= EMIT_LEN;
                        r_started <= 1'b0;
                        r_state   <= S_EMIT;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_EMIT: begin
                    if (w_skip) begin
                        r_cnt <= r_cnt - CW'(1);
                    end else if (w_emit) begin
                        r_odig    <= w_tgt_top;
                        r_olast   <= (r_cnt == CW'(1));
                        r_obad    <= 1'b0;
                        r_started <= 1'b1;
                        r_cnt     <= r_cnt - CW'(1);
                        if (r_cnt == CW'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ERR: begin
                    if (w_out_free) begin
                        r_odig   <= '0;
                        r_olast  <= 1'b1;
                        r_obad   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {{(8 - DIG_W){1'b0}}, r_odig};
    assign o_m_tlast  = r_olast;
    assign o_m_tuser  = r_obad;

    a_dec_no_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_dec_spill.carry)
        else $error("decimal row overflowed");

    a_tgt_no_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_tgt_spill.carry)
        else $error("target row overflowed");

    a_bad_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tlast && (o_m_tdata == '0)))
        else $error("error word not marked last");

    a_digit_in_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (BASE_W'(o_m_tdata[DIG_W-1:0]) < w_tb))
        else $error("digit not below target base");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_cnt != '0))
        else $error("readout ran past the row");

endmodule
